FILE: rtl/tbhs_pkg.sv
// Shared types and constants for the serial byte engine.
`timescale 1ns / 1ps
package tbhs_pkg;

  // Operation codes; command values on the mode field map onto these one to one.
  typedef enum logic [1:0] {
    OP_IDLE       = 2'd0,
    OP_WRITE_HS   = 2'd1,
    OP_WRITE_NOHS = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  localparam logic [7:0] TOP_BIT = 8'h80;

  typedef struct packed {
    op_e        operation;
    logic [3:0] half_step;
    logic [7:0] shifter;
    logic       atn_level;
    logic       data_level;
    logic       tail_wait;
  } eng_state_t;

  typedef struct packed {
    logic       atn_drive;
    logic       data_drive;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       rejected;
  } eng_result_t;

endpackage

FILE: rtl/tbhs_step.sv
// Next-state and result logic for one tick of the serial byte engine.
`timescale 1ns / 1ps
module tbhs_step #(
  parameter int BIT_PAIRS = 4
) (
  input  tbhs_pkg::eng_state_t  state_i,
  input  logic [1:0]            mode_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  clock_line_i,
  input  logic                  data_line_i,
  output tbhs_pkg::eng_state_t  state_o,
  output tbhs_pkg::eng_result_t result_o
);
  import tbhs_pkg::*;

  localparam logic [3:0] LastEven = 4'(2 * BIT_PAIRS - 2);
  localparam logic [3:0] LastOdd  = 4'(2 * BIT_PAIRS - 1);

  always_comb begin
    eng_state_t s;
    logic       done;
    logic       rej;
    logic [7:0] rx;
    s    = state_i;
    done = 1'b0;
    rej  = 1'b0;
    rx   = 8'd0;

    if (state_i.operation == OP_IDLE) begin
      if (op_e'(mode_i) != OP_IDLE) begin
        s.operation = op_e'(mode_i);
        s.half_step = 4'd0;
        s.tail_wait = 1'b0;
        if (op_e'(mode_i) == OP_READ) begin
          s.shifter = 8'd0;
        end else begin
          s.data_level = tx_byte_i[0];
          s.shifter    = {1'b0, tx_byte_i[7:1]};
          s.atn_level  = 1'b0;
        end
      end
    end else begin
      rej = (op_e'(mode_i) != OP_IDLE);
      if (state_i.operation == OP_READ) begin
        if (!state_i.half_step[0]) begin
          if (!clock_line_i) begin
            s.shifter   = (state_i.shifter >> 1) | (data_line_i ? TOP_BIT : 8'd0);
            s.atn_level = 1'b0;
            s.half_step = state_i.half_step + 4'd1;
          end
        end else if (clock_line_i) begin
          s.shifter   = (state_i.shifter >> 1) | (data_line_i ? TOP_BIT : 8'd0);
          s.atn_level = 1'b1;
          if (state_i.half_step >= LastOdd) begin
            done        = 1'b1;
            rx          = s.shifter;
            s.operation = OP_IDLE;
            s.half_step = 4'd0;
          end else begin
            s.half_step = state_i.half_step + 4'd1;
          end
        end
      end else if (state_i.tail_wait) begin
        if (clock_line_i) begin
          s.data_level = 1'b0;
          s.tail_wait  = 1'b0;
          done         = 1'b1;
          s.operation  = OP_IDLE;
          s.half_step  = 4'd0;
        end
      end else if (!state_i.half_step[0]) begin
        if (!clock_line_i) begin
          s.data_level = state_i.shifter[0];
          s.shifter    = state_i.shifter >> 1;
          s.atn_level  = 1'b1;
          if (state_i.half_step >= LastEven) begin
            s.half_step = 4'd0;
            if (state_i.operation == OP_WRITE_NOHS) begin
              done        = 1'b1;
              s.operation = OP_IDLE;
            end else begin
              s.tail_wait = 1'b1;
            end
          end else begin
            s.half_step = state_i.half_step + 4'd1;
          end
        end
      end else if (clock_line_i) begin
        s.data_level = state_i.shifter[0];
        s.shifter    = state_i.shifter >> 1;
        s.atn_level  = 1'b0;
        s.half_step  = state_i.half_step + 4'd1;
      end
    end

    state_o             = s;
    result_o.atn_drive  = s.atn_level;
    result_o.data_drive = s.data_level;
    result_o.rx_byte    = rx;
    result_o.done_res   = done;
    result_o.busy_res   = (s.operation != OP_IDLE);
    result_o.rejected   = rej;
  end

endmodule

FILE: rtl/two_bit_handshake_serial_byte_engine_top.sv
// Top level of the host-side serial byte engine (attention, clock, data lines).
`timescale 1ns / 1ps
// Each input item is one tick: the sampled clock and data line levels plus an
// optional command (mode 0 none, 1 handshaked write, 2 plain write, 3 read).
// Every item yields exactly one result item carrying the attention and data
// drives after the tick, done, busy, a rejected flag for a command that came
// while busy, and the received byte (non-zero only in the tick that finishes
// a read). Bytes move least significant bit first over BIT_PAIRS bit pairs.
// An item is taken every clock cycle unless a pending result is stalled:
// the engine state and the result are computed in one pass of combinational
// logic from the state register and the item, and land in the state register
// and the output register at the same edge. The output register frees itself
// when it is taken, so in_ready_o follows out_ready_i whenever a result is
// pending. Handshake waits never time out.
module two_bit_handshake_serial_byte_engine_top #(
  parameter int BIT_PAIRS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] tx_byte_i,
  input  logic       clock_line_i,
  input  logic       data_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       atn_drive_o,
  output logic       data_drive_o,
  output logic [7:0] rx_byte_o,
  output logic       done_res_o,
  output logic       busy_res_o,
  output logic       rejected_o
);
  import tbhs_pkg::*;

  eng_state_t  state_q, state_d;
  eng_result_t res_q, res_d;
  logic        out_valid_q;
  logic        in_fire;

  // Output slot is free when empty or being emptied this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  tbhs_step #(
    .BIT_PAIRS(BIT_PAIRS)
  ) u_step (
    .state_i     (state_q),
    .mode_i      (mode_i),
    .tx_byte_i   (tx_byte_i),
    .clock_line_i(clock_line_i),
    .data_line_i (data_line_i),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // Engine state: idle, attention asserted, data released after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.operation  <= OP_IDLE;
      state_q.half_step  <= 4'd0;
      state_q.shifter    <= 8'd0;
      state_q.atn_level  <= 1'b1;
      state_q.data_level <= 1'b0;
      state_q.tail_wait  <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign atn_drive_o  = res_q.atn_drive;
  assign data_drive_o = res_q.data_drive;
  assign rx_byte_o    = res_q.rx_byte;
  assign done_res_o   = res_q.done_res;
  assign busy_res_o   = res_q.busy_res;
  assign rejected_o   = res_q.rejected;

endmodule

FILE: rtl/tbhs_checker.sv
// Port-level checker for the serial byte engine, bound to the top level.
`timescale 1ns / 1ps
module tbhs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       atn_drive_o,
  input logic       data_drive_o,
  input logic [7:0] rx_byte_o,
  input logic       done_res_o,
  input logic       busy_res_o,
  input logic       rejected_o
);

  logic out_fire;
  logic last_busy_q;

  assign out_fire = out_valid_o && out_ready_i;

  // Busy flag of the last delivered item; idle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_busy_q <= 1'b0;
    end else if (out_fire) begin
      last_busy_q <= busy_res_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({atn_drive_o, data_drive_o, rx_byte_o, done_res_o, busy_res_o, rejected_o}))
    else $error("result item changed while stalled");

  a_rx_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rx_byte_o != 8'd0) |-> done_res_o && !busy_res_o)
    else $error("received byte shown outside a completing read");

  a_reject_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && rejected_o |-> last_busy_q)
    else $error("command rejected while engine was idle");

  a_done_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && done_res_o |-> last_busy_q && !busy_res_o)
    else $error("operation completed without one running");

endmodule

bind two_bit_handshake_serial_byte_engine_top tbhs_checker u_tbhs_checker (.*);

FILE: verif/tb_two_bit_handshake_serial_byte_engine_top.sv
// Self-checking testbench for the serial byte engine: tick stimulus, line model and checker.
`timescale 1ns / 1ps
module tb_two_bit_handshake_serial_byte_engine_top;
  import tbhs_pkg::*;

  localparam int BIT_PAIRS = 4;
  // Last half steps of a byte; reads end on an odd one, writes on an even one.
  localparam logic [3:0] LAST_EVEN = 4'(2 * BIT_PAIRS - 2);
  localparam logic [3:0] LAST_ODD  = 4'(2 * BIT_PAIRS - 1);
  localparam int N_RANDOM = 1600;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 10;

  // One bus tick as offered to the engine.
  typedef struct packed {
    op_e        mode;
    logic [7:0] tx;
    logic       clk_l;
    logic       dat_l;
  } bus_tick_t;

  // Receiver back-pressure patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_THREE_OF_FOUR,
    RX_SPARSE
  } rx_style_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  op_e        drv_mode = OP_IDLE;
  logic [7:0] drv_tx = 8'h00;
  logic       drv_clk_l = 1'b0;
  logic       drv_dat_l = 1'b0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic       atn_drive_o;
  logic       data_drive_o;
  logic [7:0] rx_byte_o;
  logic       done_res_o;
  logic       busy_res_o;
  logic       rejected_o;

  two_bit_handshake_serial_byte_engine_top #(
    .BIT_PAIRS(BIT_PAIRS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .mode_i      (drv_mode),
    .tx_byte_i   (drv_tx),
    .clock_line_i(drv_clk_l),
    .data_line_i (drv_dat_l),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .atn_drive_o (atn_drive_o),
    .data_drive_o(data_drive_o),
    .rx_byte_o   (rx_byte_o),
    .done_res_o  (done_res_o),
    .busy_res_o  (busy_res_o),
    .rejected_o  (rejected_o)
  );

  // 10 ns clock, low phase first so the first rising edge lands at 5 ns.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Reset held at the start, released on a falling edge.
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Engine mirror: own copy of the engine state, stepped once per accepted tick.
  // ---------------------------------------------------------------------------
  op_e        eng_op    = OP_IDLE;
  logic [3:0] eng_half  = 4'd0;
  logic [7:0] eng_shift = 8'h00;
  logic       eng_atn   = 1'b1;
  logic       eng_dat   = 1'b0;
  logic       eng_tail  = 1'b0;

  int reads_done = 0;
  int hs_writes_done = 0;
  int plain_writes_done = 0;
  int rejects_seen = 0;

  task automatic engine_tick(input bus_tick_t t, output eng_result_t res);
    logic       fin;
    logic       rej;
    logic [7:0] rx;
    fin = 1'b0;
    rej = 1'b0;
    rx  = 8'h00;
    if (eng_op == OP_IDLE) begin
      // A new command: no line is looked at in this tick.
      if (t.mode != OP_IDLE) begin
        eng_op   = t.mode;
        eng_half = 4'd0;
        eng_tail = 1'b0;
        if (t.mode == OP_READ) begin
          eng_shift = 8'h00;
        end else begin
          {eng_shift, eng_dat} = {1'b0, t.tx};
          eng_atn = 1'b0;
        end
      end
    end else begin
      // Busy: any command is dropped, but the running byte still moves on.
      rej = (t.mode != OP_IDLE);
      if (eng_op == OP_READ) begin
        if (!eng_half[0]) begin
          if (!t.clk_l) begin
            eng_shift = {t.dat_l, eng_shift[7:1]};
            eng_atn   = 1'b0;
            eng_half  = eng_half + 4'd1;
          end
        end else if (t.clk_l) begin
          eng_shift = {t.dat_l, eng_shift[7:1]};
          eng_atn   = 1'b1;
          if (eng_half >= LAST_ODD) begin
            fin      = 1'b1;
            rx       = eng_shift;
            eng_op   = OP_IDLE;
            eng_half = 4'd0;
            reads_done++;
          end else begin
            eng_half = eng_half + 4'd1;
          end
        end
      end else if (eng_tail) begin
        // Handshaked write: partner acknowledges by asserting clock.
        if (t.clk_l) begin
          eng_dat  = 1'b0;
          eng_tail = 1'b0;
          fin      = 1'b1;
          eng_op   = OP_IDLE;
          eng_half = 4'd0;
          hs_writes_done++;
        end
      end else if (!eng_half[0]) begin
        if (!t.clk_l) begin
          {eng_shift, eng_dat} = {1'b0, eng_shift};
          eng_atn = 1'b1;
          if (eng_half >= LAST_EVEN) begin
            eng_half = 4'd0;
            if (eng_op == OP_WRITE_NOHS) begin
              fin    = 1'b1;
              eng_op = OP_IDLE;
              plain_writes_done++;
            end else begin
              eng_tail = 1'b1;
            end
          end else begin
            eng_half = eng_half + 4'd1;
          end
        end
      end else if (t.clk_l) begin
        {eng_shift, eng_dat} = {1'b0, eng_shift};
        eng_atn  = 1'b0;
        eng_half = eng_half + 4'd1;
      end
    end
    if (rej) rejects_seen++;
    res.atn_drive  = eng_atn;
    res.data_drive = eng_dat;
    res.rx_byte    = rx;
    res.done_res   = fin;
    res.busy_res   = (eng_op != OP_IDLE);
    res.rejected   = rej;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation: ticks are queued up front, the driver drains them.
  // ---------------------------------------------------------------------------
  bus_tick_t  tick_backlog[$];
  eng_result_t due_status[$];

  task automatic push_tick(input op_e m, input logic [7:0] tx, input logic c, input logic d);
    bus_tick_t t;
    t.mode  = m;
    t.tx    = tx;
    t.clk_l = c;
    t.dat_l = d;
    tick_backlog.push_back(t);
  endtask

  // Mode for a tick inside a running byte: mostly none, now and then a stray
  // command that must be turned away.
  function automatic op_e stray_mode();
    if ($urandom_range(0, 11) == 0) return op_e'($urandom_range(1, 3));
    return OP_IDLE;
  endfunction

  // A well-formed byte: the command, then the partner stepping the clock
  // line through the levels the engine waits for, with random lag.
  task automatic queue_byte(input op_e cmd);
    int n_steps;
    logic need;
    n_steps = (cmd == OP_READ) ? 2 * BIT_PAIRS : 2 * BIT_PAIRS - 1;
    push_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
    for (int i = 0; i <= n_steps; i++) begin
      if (i == n_steps && cmd != OP_WRITE_HS) break;
      // Tail wait of a handshaked write wants clock asserted.
      need = (i == n_steps) ? 1'b1 : i[0];
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4))
          push_tick(stray_mode(), 8'($urandom), !need, 1'($urandom));
      end
      push_tick(stray_mode(), 8'($urandom), need, 1'($urandom));
    end
  endtask

  task automatic fill_backlog();
    int target;
    // Directed: an idle tick, then one of each command on a prompt partner.
    push_tick(OP_IDLE, 8'hFF, 1'b1, 1'b1);
    // handshaked write of A5, with a stray read on an advancing tick
    push_tick(OP_WRITE_HS, 8'hA5, 1'b0, 1'b0);
    for (int i = 0; i < 2 * BIT_PAIRS - 1; i++)
      push_tick((i == 1) ? OP_READ : OP_IDLE, 8'h00, i[0], 1'b0);
    push_tick(OP_IDLE, 8'h00, 1'b1, 1'b0);
    // read of bit pattern 1,1,0,1,0,0,1,1 (CB)
    push_tick(OP_READ, 8'h00, 1'b1, 1'b1);
    for (int i = 0; i < 2 * BIT_PAIRS; i++)
      push_tick(OP_IDLE, 8'hFF, i[0], 1'(8'hCB >> i));
    // plain write of FF; the finishing tick also carries a rejected command
    push_tick(OP_WRITE_NOHS, 8'hFF, 1'b1, 1'b1);
    for (int i = 0; i < 2 * BIT_PAIRS - 1; i++)
      push_tick((i == 2 * BIT_PAIRS - 2) ? OP_WRITE_HS : OP_IDLE, 8'h00, i[0], 1'b1);

    // Random: mostly complete bytes, some raw noise and idle gaps.
    target = tick_backlog.size() + N_RANDOM;
    while (tick_backlog.size() < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8))
          push_tick(op_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(0, 3))
          push_tick(OP_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
        queue_byte(op_e'($urandom_range(1, 3)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of ticks with random gaps, changes on the falling edge.
  // ---------------------------------------------------------------------------
  int        ticks_taken = 0;
  int        ticks_sent = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  bus_tick_t next_tick;

  // A tick is still on offer while more have been sent than taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || ticks_taken == ticks_sent)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_backlog.size() != 0) begin
        next_tick = tick_backlog.pop_front();
        ticks_sent++;
        in_valid  <= 1'b1;
        drv_mode  <= next_tick.mode;
        drv_tx    <= next_tick.tx;
        drv_clk_l <= next_tick.clk_l;
        drv_dat_l <= next_tick.dat_l;
        if (burst_left <= 1) begin
          // some bursts run back to back, some gaps are long
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(5, 12);
            default: gap_left = $urandom_range(1, 3);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus two long hold-offs that fill the engine.
  // ---------------------------------------------------------------------------
  int        hold_left = 0;
  int        holds_done = 0;
  int        pat_left = 0;
  logic [1:0] pat_phase = 2'd0;
  rx_style_e rx_style = RX_ALWAYS;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && ticks_taken >= 500 + 700 * holds_done) begin
      hold_left = HOLD_CYCLES - 1;
      holds_done++;
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
        pat_left = $urandom_range(32, 200);
      end
      pat_left--;
      pat_phase = pat_phase + 2'd1;
      case (rx_style)
        RX_ALWAYS:        out_ready <= 1'b1;
        RX_COIN:          out_ready <= 1'($urandom);
        RX_THREE_OF_FOUR: out_ready <= (pat_phase != 2'd3);
        default:          out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker, on the rising edge.
  // ---------------------------------------------------------------------------
  int err_cnt = 0;
  int results_seen = 0;

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    err_cnt++;
    $display("tb: result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin : watch
    eng_result_t want;
    eng_result_t pred;
    if (rst_ni) begin
      // Result leaving the engine: compare with the oldest expectation.
      if (out_valid_o && out_ready) begin
        if (due_status.size() == 0) begin
          flag_mismatch("result with nothing expected, rx_byte", rx_byte_o, 8'h00);
        end else begin
          want = due_status.pop_front();
          if (atn_drive_o !== want.atn_drive)
            flag_mismatch("atn_drive", 8'(atn_drive_o), 8'(want.atn_drive));
          if (data_drive_o !== want.data_drive)
            flag_mismatch("data_drive", 8'(data_drive_o), 8'(want.data_drive));
          if (rx_byte_o !== want.rx_byte)
            flag_mismatch("rx_byte", rx_byte_o, want.rx_byte);
          if (done_res_o !== want.done_res)
            flag_mismatch("done_res", 8'(done_res_o), 8'(want.done_res));
          if (busy_res_o !== want.busy_res)
            flag_mismatch("busy_res", 8'(busy_res_o), 8'(want.busy_res));
          if (rejected_o !== want.rejected)
            flag_mismatch("rejected", 8'(rejected_o), 8'(want.rejected));
        end
        results_seen++;
      end
      // Tick taken by the engine: step the mirror and queue what it says.
      if (in_valid && in_ready_o) begin
        engine_tick({drv_mode, drv_tx, drv_clk_l, drv_dat_l}, pred);
        due_status.push_back(pred);
        ticks_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control.
  // ---------------------------------------------------------------------------
  initial begin
    fill_backlog();
    while (tick_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (due_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_status.size() != 0)
      flag_mismatch("expected results left over, count", 8'(due_status.size()), 8'h00);
    $display("tb: %0d ticks in, %0d results out, %0d receiver hold-offs",
             ticks_taken, results_seen, holds_done);
    $display("tb: completed %0d reads, %0d handshaked writes, %0d plain writes; %0d rejects",
             reads_done, hs_writes_done, plain_writes_done, rejects_seen);
    if (err_cnt == 0) begin
      $display("tb_two_bit_handshake_serial_byte_engine_top: PASS");
    end else begin
      $display("tb: %0d mismatches", err_cnt);
      $display("tb_two_bit_handshake_serial_byte_engine_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb: timeout");
    $display("tb_two_bit_handshake_serial_byte_engine_top: FAIL");
    $finish;
  end

endmodule

FILE: two_bit_handshake_serial_byte_engine_top.f
rtl/tbhs_pkg.sv
rtl/tbhs_step.sv
rtl/two_bit_handshake_serial_byte_engine_top.sv
rtl/tbhs_checker.sv
verif/tb_two_bit_handshake_serial_byte_engine_top.sv
